// ----- hdl/cpa_pkg.sv -----
// Shared types and constants of the contiguous page allocator.
`timescale 1ns / 1ps
`default_nettype none

package cpa_pkg;

  // Fixed widths of the transaction fields.
  localparam int ACTION_W  = 2;
  localparam int COUNT_W   = 11;
  localparam int PAGE_W    = 10;
  localparam int PURPOSE_W = 4;
  localparam int START_W   = 10;

  // Stream widths, padded to whole bytes.
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 16;

  // Page type codes.
  localparam int TYPE_AVAIL    = 0;
  localparam int TYPE_RESERVED = 1;

  // Requested operation, carried on the input tuser.
  typedef enum logic [ACTION_W-1:0] {
    ACT_ALLOC    = 2'd0,
    ACT_FREE     = 2'd1,
    ACT_SET_TYPE = 2'd2
  } cpa_action_e;

  // One request as seen by the sequencer.
  typedef struct packed {
    cpa_action_e            action;
    logic [COUNT_W-1:0]     page_count;
    logic [PAGE_W-1:0]      first_page;
    logic [PURPOSE_W-1:0]   purpose;
  } cpa_cmd_t;

  // One answer from the sequencer.
  typedef struct packed {
    logic [START_W-1:0] run_start;
    logic               granted;
  } cpa_res_t;

endpackage

`default_nettype wire

// ----- hdl/cpa_step.sv -----
// Shared index stepper: increments the walk index and flags the last step.
`timescale 1ns / 1ps
`default_nettype none

module cpa_step #(
  parameter int CW = 12
) (
  input  wire logic [CW-1:0] idx_i,
  input  wire logic [CW-1:0] lim_i,
  output logic      [CW-1:0] next_o,
  output logic               last_o
);

  // The next index, and whether it reaches the end of the walk.
  assign next_o = idx_i + CW'(1);
  assign last_o = (next_o >= lim_i);

endmodule

`default_nettype wire

// ----- hdl/cpa_dir_ram.sv -----
// Page directory memory: a reference count and a type code for each page.
`timescale 1ns / 1ps
`default_nettype none

module cpa_dir_ram #(
  parameter int DEPTH     = 1024,
  parameter int AW        = 10,
  parameter int REF_BITS  = 8,
  parameter int TYPE_BITS = 4
) (
  input  wire logic                 clk_i,
  input  wire logic                 rd_en_i,
  input  wire logic [AW-1:0]        rd_addr_i,
  output logic      [REF_BITS-1:0]  rd_ref_o,
  output logic      [TYPE_BITS-1:0] rd_type_o,
  input  wire logic [AW-1:0]        wr_addr_i,
  input  wire logic                 wr_ref_en_i,
  input  wire logic [REF_BITS-1:0]  wr_ref_i,
  input  wire logic                 wr_type_en_i,
  input  wire logic [TYPE_BITS-1:0] wr_type_i
);

  logic [REF_BITS-1:0]  ref_mem  [DEPTH];
  logic [TYPE_BITS-1:0] type_mem [DEPTH];

  // Separate write enables let a type update keep the count as it is.
  always_ff @(posedge clk_i) begin
    if (wr_ref_en_i) begin
      ref_mem[wr_addr_i] <= wr_ref_i;
    end
    if (wr_type_en_i) begin
      type_mem[wr_addr_i] <= wr_type_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_ref_o  <= ref_mem[rd_addr_i];
      rd_type_o <= type_mem[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ----- hdl/cpa_walk.sv -----
// Sequencer that walks the page directory for clear, scan, mark and free.
`timescale 1ns / 1ps
`default_nettype none

module cpa_walk
  import cpa_pkg::*;
#(
  parameter int NUM_PAGES = 1024,
  parameter int TYPE_BITS = 4,
  parameter int REF_BITS  = 8
) (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     cmd_valid_i,
  output logic          cmd_ready_o,
  input  wire cpa_cmd_t cmd_i,
  output logic          res_valid_o,
  input  wire logic     res_ready_i,
  output cpa_res_t      res_o
);

  localparam int AW    = $clog2(NUM_PAGES);
  localparam int NPW   = $clog2(NUM_PAGES + 1);
  localparam int CW    = ((NPW > COUNT_W) ? NPW : COUNT_W) + 1;
  localparam logic [CW-1:0] NUM_PAGES_C = CW'(NUM_PAGES);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_MARK,
    ST_FREE,
    ST_DONE
  } state_e;

  state_e               state_q, state_d;
  logic [CW-1:0]        idx_q, idx_d;
  logic [CW-1:0]        lim_q, lim_d;
  logic                 issue_q, issue_d;
  logic                 pend_q, pend_d;
  logic [CW-1:0]        ev_q, ev_d;
  logic [CW-1:0]        run_len_q, run_len_d;
  logic [CW-1:0]        run_first_q, run_first_d;
  logic [CW-1:0]        want_q, want_d;
  logic [TYPE_BITS-1:0] purpose_q, purpose_d;
  cpa_res_t             res_q, res_d;

  logic [CW-1:0]        step_lim;
  logic [CW-1:0]        step_next;
  logic                 step_last;

  logic                 rd_en;
  logic [AW-1:0]        rd_addr;
  logic [REF_BITS-1:0]  rd_ref;
  logic [TYPE_BITS-1:0] rd_type;
  logic [AW-1:0]        wr_addr;
  logic                 wr_ref_en;
  logic [REF_BITS-1:0]  wr_ref;
  logic                 wr_type_en;
  logic [TYPE_BITS-1:0] wr_type;

  logic                 pg_free;
  logic [CW-1:0]        run_first_sel;
  logic [CW-1:0]        run_len_inc;
  logic [CW-1:0]        first_ext;
  logic [CW-1:0]        end_sum;
  logic [CW-1:0]        end_lim;

  // The one index stepper shared by every walk.
  cpa_step #(
    .CW (CW)
  ) u_step (
    .idx_i  (idx_q),
    .lim_i  (step_lim),
    .next_o (step_next),
    .last_o (step_last)
  );

  cpa_dir_ram #(
    .DEPTH     (NUM_PAGES),
    .AW        (AW),
    .REF_BITS  (REF_BITS),
    .TYPE_BITS (TYPE_BITS)
  ) u_dir_ram (
    .clk_i        (clk_i),
    .rd_en_i      (rd_en),
    .rd_addr_i    (rd_addr),
    .rd_ref_o     (rd_ref),
    .rd_type_o    (rd_type),
    .wr_addr_i    (wr_addr),
    .wr_ref_en_i  (wr_ref_en),
    .wr_ref_i     (wr_ref),
    .wr_type_en_i (wr_type_en),
    .wr_type_i    (wr_type)
  );

  // Scan helpers: page test on the returned data and run bookkeeping.
  assign step_lim      = ((state_q == ST_MARK) || (state_q == ST_FREE)) ? lim_q : NUM_PAGES_C;
  assign pg_free       = (rd_ref == '0) && (rd_type == TYPE_BITS'(TYPE_AVAIL));
  assign run_first_sel = (run_len_q == '0) ? ev_q : run_first_q;
  assign run_len_inc   = run_len_q + CW'(1);

  // Free range end, clipped to the directory size.
  assign first_ext = CW'(cmd_i.first_page);
  assign end_sum   = first_ext + CW'(cmd_i.page_count);
  assign end_lim   = (end_sum > NUM_PAGES_C) ? NUM_PAGES_C : end_sum;

  assign cmd_ready_o = (state_q == ST_IDLE);
  assign res_valid_o = (state_q == ST_DONE);
  assign res_o       = res_q;
  assign rd_addr     = idx_q[AW-1:0];

  // Next-state logic of the sequencer.
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    lim_d       = lim_q;
    issue_d     = issue_q;
    pend_d      = pend_q;
    ev_d        = ev_q;
    run_len_d   = run_len_q;
    run_first_d = run_first_q;
    want_d      = want_q;
    purpose_d   = purpose_q;
    res_d       = res_q;
    rd_en       = 1'b0;
    wr_addr     = idx_q[AW-1:0];
    wr_ref_en   = 1'b0;
    wr_ref      = '0;
    wr_type_en  = 1'b0;
    wr_type     = TYPE_BITS'(TYPE_AVAIL);

    case (state_q)
      ST_CLEAR: begin
        // Bring every page to its reset contents, one page a cycle.
        wr_ref_en  = 1'b1;
        wr_type_en = 1'b1;
        if (idx_q == '0) begin
          wr_type = TYPE_BITS'(TYPE_RESERVED);
        end
        idx_d = step_next;
        if (step_last) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (cmd_valid_i) begin
          purpose_d = TYPE_BITS'(cmd_i.purpose);
          want_d    = CW'(cmd_i.page_count);
          res_d     = '{run_start: '0, granted: 1'b0};
          case (cmd_i.action)
            ACT_ALLOC: begin
              if (cmd_i.page_count == '0) begin
                state_d = ST_DONE;
              end else begin
                idx_d     = CW'(1);
                issue_d   = 1'b1;
                pend_d    = 1'b0;
                run_len_d = '0;
                state_d   = ST_SCAN;
              end
            end
            ACT_FREE: begin
              idx_d = first_ext;
              lim_d = end_lim;
              res_d = '{run_start: '0, granted: 1'b1};
              if (first_ext >= end_lim) begin
                state_d = ST_DONE;
              end else begin
                state_d = ST_FREE;
              end
            end
            ACT_SET_TYPE: begin
              if ((first_ext != '0) && (first_ext < NUM_PAGES_C)) begin
                wr_addr    = first_ext[AW-1:0];
                wr_type_en = 1'b1;
                wr_type    = TYPE_BITS'(cmd_i.purpose);
                res_d      = '{run_start: '0, granted: 1'b1};
              end
              state_d = ST_DONE;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end

      ST_SCAN: begin
        // Issue one read a cycle and judge the page read in the previous cycle.
        rd_en  = issue_q;
        pend_d = issue_q;
        ev_d   = idx_q;
        if (issue_q) begin
          idx_d   = step_next;
          issue_d = !step_last;
        end
        if (pend_q) begin
          if (pg_free) begin
            run_first_d = run_first_sel;
            run_len_d   = run_len_inc;
            if (run_len_inc == want_q) begin
              idx_d   = run_first_sel;
              lim_d   = ev_q + CW'(1);
              issue_d = 1'b0;
              pend_d  = 1'b0;
              res_d   = '{run_start: run_first_sel[START_W-1:0], granted: 1'b1};
              state_d = ST_MARK;
            end
          end else begin
            run_len_d = '0;
          end
        end else if (!issue_q) begin
          res_d   = '{run_start: '0, granted: 1'b0};
          state_d = ST_DONE;
        end
      end

      ST_MARK: begin
        // The run was free, so every count goes from zero to one.
        wr_ref_en  = 1'b1;
        wr_ref     = REF_BITS'(1);
        wr_type_en = 1'b1;
        wr_type    = purpose_q;
        idx_d      = step_next;
        if (step_last) begin
          state_d = ST_DONE;
        end
      end

      ST_FREE: begin
        // Page zero stays reserved.
        if (idx_q != '0) begin
          wr_ref_en  = 1'b1;
          wr_type_en = 1'b1;
        end
        idx_d = step_next;
        if (step_last) begin
          state_d = ST_DONE;
        end
      end

      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      idx_q       <= '0;
      lim_q       <= '0;
      issue_q     <= 1'b0;
      pend_q      <= 1'b0;
      ev_q        <= '0;
      run_len_q   <= '0;
      run_first_q <= '0;
      want_q      <= '0;
      purpose_q   <= '0;
      res_q       <= '0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      lim_q       <= lim_d;
      issue_q     <= issue_d;
      pend_q      <= pend_d;
      ev_q        <= ev_d;
      run_len_q   <= run_len_d;
      run_first_q <= run_first_d;
      want_q      <= want_d;
      purpose_q   <= purpose_d;
      res_q       <= res_d;
    end
  end

endmodule

`default_nettype wire

// ----- hdl/contiguous_page_allocator_core.sv -----
// Contiguous page allocator: stream ports, result register and sequencer.
//
// A first-fit allocator over a directory of NUM_PAGES physical pages, each
// holding a reference count and a type code in an on-chip memory with one
// read and one write port. The block handles one transaction at a time and
// holds s_axis_tready low while it works. Allocate scans upward one page per
// cycle from page one until a run fits, then writes the run one page per
// cycle. Free writes one page per cycle over its clipped range; set type and
// rejected requests go straight to the result. All walks share the directory
// memory and one index stepper. After reset a clearing pass writes every
// page once before the first transaction is taken. A finished result
// waits in an output register, so the next transaction may enter while the
// previous result is still held on the master side.
`timescale 1ns / 1ps
`default_nettype none

module contiguous_page_allocator_core
  import cpa_pkg::*;
#(
  parameter int NUM_PAGES = 1024,
  parameter int TYPE_BITS = 4,
  parameter int REF_BITS  = 8
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // page_count [10:0], first_page [20:11], purpose [24:21], zero [31:25]
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // action [1:0]
  input  wire logic [ACTION_W-1:0]    s_axis_tuser,
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // run_start [9:0], granted [10], zero [15:11]
  output logic      [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int IN_USED_W  = COUNT_W + PAGE_W + PURPOSE_W;
  localparam int OUT_USED_W = START_W + 1;

  cpa_cmd_t cmd;
  cpa_res_t res;
  logic     res_valid;
  logic     res_ready;
  logic     out_valid_q, out_valid_d;
  cpa_res_t out_q, out_d;

  // Unpack the slave-side transaction.
  assign cmd.action     = cpa_action_e'(s_axis_tuser);
  assign cmd.page_count = s_axis_tdata[COUNT_W-1:0];
  assign cmd.first_page = s_axis_tdata[COUNT_W+PAGE_W-1:COUNT_W];
  assign cmd.purpose    = s_axis_tdata[IN_USED_W-1:COUNT_W+PAGE_W];

  cpa_walk #(
    .NUM_PAGES (NUM_PAGES),
    .TYPE_BITS (TYPE_BITS),
    .REF_BITS  (REF_BITS)
  ) u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (s_axis_tvalid),
    .cmd_ready_o (s_axis_tready),
    .cmd_i       (cmd),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register: takes a result whenever it is empty or being drained.
  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  // Pack the master-side transaction.
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W - OUT_USED_W){1'b0}}, out_q.granted, out_q.run_start};

  // The sequencer is busy in the cycle after it takes a transaction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("allocator ready straight after taking a transaction");

  // A refused request never reports a run start.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tdata[START_W]) |-> (m_axis_tdata[START_W-1:0] == '0))
    else $error("failed result carries a non-zero run start");

  // A result is only offered while no new transaction can be taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> !s_axis_tready)
    else $error("result offered while the sequencer is idle");

endmodule

`default_nettype wire
